### rtl/fic_pkg.sv
// ----------------------------------------------------------------------------
// fic_pkg: shared types and constants for the binary64 / int64 converter.
// Holds the command codes, the input and result beat structs and constants.
// ----------------------------------------------------------------------------
package fic_pkg;

	typedef enum logic [1:0] {
		CMD_DBL_TO_SIGNED   = 2'd0,
		CMD_DBL_TO_UNSIGNED = 2'd1,
		CMD_SIGNED_TO_DBL   = 2'd2,
		CMD_UNSIGNED_TO_DBL = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [63:0] operand;
		logic [6:0]  source_width;
	} in_beat_t;

	typedef struct packed {
		logic [63:0] converted;
		logic        width_refused;
	} out_beat_t;

	localparam logic [51:0] FRAC_MASK = 52'hF_FFFF_FFFF_FFFF;
	localparam logic [63:0] TOP_BIT   = 64'h8000_0000_0000_0000;
	localparam logic [10:0] EXP_UNIT  = 11'd1075;
	localparam logic [10:0] EXP_SAT   = 11'd1086;

endpackage

### rtl/fic_int_to_dbl.sv
// ----------------------------------------------------------------------------
// fic_int_to_dbl: signed 64-bit integer to binary64.
// Leading-zero count, normalising shift and round to nearest, ties to even.
// ----------------------------------------------------------------------------
module fic_int_to_dbl (
	input  logic [63:0] value,
	output logic [63:0] result
);
	import fic_pkg::*;

	logic        sgn;
	logic [63:0] mag;
	logic [5:0]  lz;
	logic [63:0] norm;
	logic [52:0] man;
	logic        up;
	logic [10:0] ex;

	// Priority search for the leading one; a plain encoder, not a serial chain.
	always_comb begin
		lz = 6'd63;
		for (int i = 0; i < 64; i++) begin
			if (mag[i]) begin
				lz = 6'(63 - i);
			end
		end
	end

	assign sgn  = value[63];
	assign mag  = sgn ? (~value + 64'd1) : value;
	assign norm = mag << lz;
	assign up   = norm[10] & ((|norm[9:0]) | norm[11]);
	assign man  = {1'b0, norm[62:11]} + {52'd0, up};
	assign ex   = EXP_SAT - {5'd0, lz} + {10'd0, man[52]};

	always_comb begin
		if (value == 64'd0) begin
			result = 64'd0;
		end else begin
			result = {sgn, ex, man[51:0]};
		end
	end

endmodule

### rtl/fp64_integer_convert.sv
// ----------------------------------------------------------------------------
// fp64_integer_convert: binary64 <-> 64-bit integer conversion unit.
// A beat taken at one edge appears on the result ports, marked by done,
// during the following cycle. Throughput is one beat per cycle, set by the
// single register stage; busy is held low throughout since the receiver
// cannot stall. Reset clears only the done strobe.
// ----------------------------------------------------------------------------
module fp64_integer_convert (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  fic_pkg::in_beat_t  in_beat,
	output logic               done,
	output fic_pkg::out_beat_t out_beat
);
	import fic_pkg::*;

	logic        sgn;
	logic [10:0] e;
	logic [52:0] sig;
	logic [63:0] mag;
	logic [63:0] d2s;
	logic [63:0] d2u;
	logic [63:0] i2d_src;
	logic [63:0] i2d_res;
	logic [63:0] wmask;
	logic        refuse;
	logic [10:0] amt;
	out_beat_t   res;
	out_beat_t   out_q;
	logic        done_q;

	// The shared integer-to-double path serves both signed and masked sources.
	fic_int_to_dbl u_i2d (
		.value  (i2d_src),
		.result (i2d_res)
	);

	assign sgn = in_beat.operand[63];
	assign e   = in_beat.operand[62:52];
	assign sig = {(e != 11'd0), in_beat.operand[51:0]};

	// Truncating double to signed; right shifts beyond 63 clamp to 63.
	always_comb begin
		if (e >= EXP_UNIT) begin
			amt = e - EXP_UNIT;
			mag = {11'd0, sig} << amt[3:0];
		end else begin
			amt = EXP_UNIT - e;
			if (amt > 11'd63) begin
				amt = 11'd63;
			end
			mag = {11'd0, sig} >> amt[5:0];
		end
		if (e >= EXP_SAT) begin
			d2s = TOP_BIT;
		end else begin
			d2s = sgn ? (~mag + 64'd1) : mag;
		end
	end

	// The positive band at exponent 1086 lies above the signed range.
	assign d2u = (!sgn && e == EXP_SAT) ? {1'b1, in_beat.operand[51:0], 11'd0} : d2s;

	assign refuse  = (in_beat.source_width == 7'd0) || (in_beat.source_width >= 7'd64);
	assign wmask   = (64'd1 << in_beat.source_width[5:0]) - 64'd1;
	assign i2d_src = (in_beat.command == CMD_UNSIGNED_TO_DBL) ?
			(in_beat.operand & wmask) : in_beat.operand;

	always_comb begin
		res = '0;
		unique case (cmd_t'(in_beat.command))
			CMD_DBL_TO_SIGNED:   res.converted = d2s;
			CMD_DBL_TO_UNSIGNED: res.converted = d2u;
			CMD_SIGNED_TO_DBL:   res.converted = i2d_res;
			CMD_UNSIGNED_TO_DBL: begin
				res.width_refused = refuse;
				res.converted     = refuse ? 64'd0 : i2d_res;
			end
			default:             res = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			out_q <= res;
		end
	end

	assign busy     = 1'b0;
	assign done     = done_q;
	assign out_beat = out_q;

endmodule

### rtl/fic_checker.sv
// ----------------------------------------------------------------------------
// fic_checker: port-level checks on the conversion unit.
// Bound to the top level; watches the handshake and the result beats.
// ----------------------------------------------------------------------------
module fic_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input fic_pkg::in_beat_t  in_beat,
	input fic_pkg::out_beat_t out_beat
);
	import fic_pkg::*;

	// Every accepted beat yields a result in the next cycle.
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> done) else $error("missing result");

	// No result without a beat taken in the cycle before.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!start |=> !done) else $error("spurious result");

	// The refusal flag comes only from an unsigned source; width 0 or 64 or more refuses.
	a_refuse_src: assert property (@(posedge clk) disable iff (!arst_n)
		done && out_beat.width_refused |->
		$past(in_beat.command) == CMD_UNSIGNED_TO_DBL) else $error("bad refusal");

	// A refused beat carries a zero result.
	a_refuse_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && out_beat.width_refused |-> out_beat.converted == 64'd0)
		else $error("refused result not zero");

endmodule

bind fp64_integer_convert fic_checker u_fic_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.done     (done),
	.in_beat  (in_beat),
	.out_beat (out_beat)
);

### test/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the binary64 / int64 conversion unit.
// Directed corner beats, then random beats under varied sender idling; each
// result beat is checked field by field against an in-bench predictor.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import fic_pkg::*;

	localparam int CLK_HALF    = 6;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_BEATS = 1525;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      start = 1'b0;
	logic      busy;
	in_beat_t  in_beat = '0;
	logic      done;
	out_beat_t out_beat;

	in_beat_t  pending_beats[$];
	out_beat_t awaited_results[$];
	int        mismatches = 0;
	int        results_seen = 0;
	int        cycles = 0;
	int        idle_pct = 18;
	bit        hold_send = 1'b0;
	int        per_cmd[4] = '{0, 0, 0, 0};

	fp64_integer_convert DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.in_beat(in_beat), .done(done), .out_beat(out_beat)
	);

	always #(CLK_HALF) clk = ~clk;

	// Truncate a double toward zero; exponents of 1086 and above saturate.
	function automatic logic [63:0] trunc_to_int(input logic [63:0] x);
		logic [10:0] e;
		logic [63:0] sig, mag;
		int          sh;
		e = x[62:52];
		sig = {11'd0, (e != 0), x[51:0]};
		if (e >= EXP_SAT)
			return TOP_BIT;
		if (e >= EXP_UNIT)
			mag = sig << (e - EXP_UNIT);
		else begin
			sh = int'(EXP_UNIT) - int'(e);
			if (sh > 63)
				sh = 63;
			mag = sig >> sh;
		end
		return x[63] ? (~mag + 64'd1) : mag;
	endfunction

	// Signed integer to double, rounding to nearest with ties to even.
	function automatic logic [63:0] int_to_double(input logic [63:0] v);
		logic [63:0] mag, norm;
		logic [52:0] man;
		logic [10:0] ex;
		int          lz;
		if (v == 0)
			return 64'd0;
		mag = v[63] ? (~v + 64'd1) : v;
		lz = 0;
		norm = mag;
		while (!norm[63] && lz < 63) begin
			norm = norm << 1;
			lz++;
		end
		ex = EXP_SAT - 11'(lz);
		man = {1'b0, norm[62:11]};
		if (norm[10] && ((norm[9:0] != 0) || man[0]))
			man = man + 53'd1;
		ex = ex + 11'(man[52]);
		return {v[63], ex, man[51:0]};
	endfunction

	function automatic out_beat_t convert_beat(input in_beat_t b);
		out_beat_t r;
		r = '0;
		case (cmd_t'(b.command))
			CMD_DBL_TO_SIGNED: begin
				r.converted = trunc_to_int(b.operand);
			end
			CMD_DBL_TO_UNSIGNED: begin
				if (!b.operand[63] && b.operand[62:52] == EXP_SAT)
					r.converted = {1'b1, b.operand[51:0], 11'd0};
				else
					r.converted = trunc_to_int(b.operand);
			end
			CMD_SIGNED_TO_DBL: begin
				r.converted = int_to_double(b.operand);
			end
			default: begin
				if (b.source_width == 0 || b.source_width >= 64)
					r.width_refused = 1'b1;
				else
					r.converted = int_to_double(b.operand &
						((64'd1 << b.source_width) - 64'd1));
			end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("MISMATCH %s: got %h expected %h at cycle %0d", what, got, want, cycles);
		mismatches++;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Random double with the exponent steered towards the interesting bands.
	function automatic logic [63:0] rand_double();
		logic [63:0] d;
		d = rand64();
		case ($urandom_range(0, 5))
			0: d[62:52] = 11'($urandom_range(1023, 1100));
			1: d[62:52] = 11'($urandom_range(1080, 1090));
			2: d[62:52] = EXP_SAT;
			3: d[62:52] = 11'($urandom_range(0, 1023));
			default: ;
		endcase
		return d;
	endfunction

	function automatic in_beat_t rand_beat();
		in_beat_t b;
		b.command = 2'($urandom_range(0, 3));
		b.source_width = 7'($urandom_range(0, 127));
		if ($urandom_range(0, 3) != 0)
			b.source_width = 7'($urandom_range(1, 64));
		if (b.command < 2) begin
			b.operand = rand_double();
		end else begin
			b.operand = rand64();
			// Short magnitudes exercise normalisation and rounding ties.
			if ($urandom_range(0, 2) == 0)
				b.operand = b.operand >> $urandom_range(0, 63);
		end
		return b;
	endfunction

	// The driver: a beat is taken at an edge where start is high and busy low.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			in_beat <= '0;
		end else begin
			if (start && !busy) begin
				awaited_results.push_back(convert_beat(in_beat));
				per_cmd[in_beat.command]++;
			end
			if (start && busy) begin
				// The current beat has not been taken; keep it presented.
			end else if (pending_beats.size() > 0 && !hold_send &&
					$urandom_range(0, 99) >= idle_pct) begin
				start <= 1'b1;
				in_beat <= pending_beats.pop_front();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// The monitor: each result beat lasts one cycle and is taken at its edge.
	always @(posedge clk) begin
		cycles++;
		if (arst_n && done) begin
			results_seen++;
			if (awaited_results.size() == 0) begin
				report_mismatch("unexpected result", out_beat.converted, 64'd0);
			end else begin
				out_beat_t want;
				want = awaited_results.pop_front();
				if (out_beat.converted !== want.converted)
					report_mismatch("converted", out_beat.converted, want.converted);
				if (out_beat.width_refused !== want.width_refused)
					report_mismatch("width_refused", 64'(out_beat.width_refused),
						64'(want.width_refused));
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("fp64_integer_convert verification failed");
			$finish;
		end
	end

	// Checked at the falling edge, once the driver and monitor have settled.
	task automatic wait_drained();
		@(negedge clk);
		while (pending_beats.size() > 0 || start || awaited_results.size() > 0)
			@(negedge clk);
	endtask

	task automatic add_beat(input cmd_t c, input logic [63:0] op, input int w);
		in_beat_t b;
		b.command = c;
		b.operand = op;
		b.source_width = 7'(w);
		pending_beats.push_back(b);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed corners: saturation, the unsigned high band, zero, rounding
		// ties, the most negative integer and the refused widths 0, 64 and 127.
		add_beat(CMD_DBL_TO_SIGNED,   64'h7FF8_0000_0000_0000, 1);
		add_beat(CMD_DBL_TO_SIGNED,   64'hFFF0_0000_0000_0000, 1);
		add_beat(CMD_DBL_TO_SIGNED,   64'hC3DF_FFFF_FFFF_FFFF, 1);
		add_beat(CMD_DBL_TO_SIGNED,   64'h0000_0000_0000_0001, 1);
		add_beat(CMD_DBL_TO_SIGNED,   64'hBFF8_0000_0000_0000, 1);
		add_beat(CMD_DBL_TO_UNSIGNED, 64'h43EF_FFFF_FFFF_FFFF, 1);
		add_beat(CMD_DBL_TO_UNSIGNED, 64'h43E0_0000_0000_0000, 1);
		add_beat(CMD_DBL_TO_UNSIGNED, 64'hC3E0_0000_0000_0000, 1);
		add_beat(CMD_DBL_TO_UNSIGNED, 64'h43F0_0000_0000_0000, 1);
		add_beat(CMD_DBL_TO_UNSIGNED, 64'hBFF0_0000_0000_0000, 1);
		add_beat(CMD_SIGNED_TO_DBL,   64'd0, 1);
		add_beat(CMD_SIGNED_TO_DBL,   64'h8000_0000_0000_0000, 1);
		add_beat(CMD_SIGNED_TO_DBL,   64'h7FFF_FFFF_FFFF_FFFF, 1);
		add_beat(CMD_SIGNED_TO_DBL,   64'h0020_0000_0000_0001, 1);
		add_beat(CMD_SIGNED_TO_DBL,   64'h0020_0000_0000_0003, 1);
		add_beat(CMD_SIGNED_TO_DBL,   64'hFFFF_FFFF_FFFF_FFFF, 1);
		add_beat(CMD_UNSIGNED_TO_DBL, 64'hFFFF_FFFF_FFFF_FFFF, 64);
		add_beat(CMD_UNSIGNED_TO_DBL, 64'hFFFF_FFFF_FFFF_FFFF, 0);
		add_beat(CMD_UNSIGNED_TO_DBL, 64'hFFFF_FFFF_FFFF_FFFF, 127);
		add_beat(CMD_UNSIGNED_TO_DBL, 64'hFFFF_FFFF_FFFF_FFFF, 63);
		add_beat(CMD_UNSIGNED_TO_DBL, 64'hFFFF_FFFF_FFFF_FFFF, 1);
		add_beat(CMD_UNSIGNED_TO_DBL, 64'h0000_0000_0000_0000, 32);
		wait_drained();

		// Three random phases: sender idles rarely, often, then not at all.
		// Between phases the sender holds off until every result is back.
		for (int phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 18 : (phase == 1) ? 56 : 0;
			for (int i = 0; i < RANDOM_BEATS / 3; i++)
				pending_beats.push_back(rand_beat());
			wait_drained();
		end

		repeat (4) @(posedge clk);
		$display("Covered %0d result beats: %0d d2s, %0d d2u, %0d s2d, %0d u2d.",
			results_seen, per_cmd[0], per_cmd[1], per_cmd[2], per_cmd[3]);
		$display("Sender idling at 18, 56 and 0 percent, with drained pauses between.");
		if (mismatches == 0 && awaited_results.size() == 0)
			$display("fp64_integer_convert verification clean");
		else
			$display("fp64_integer_convert verification failed");
		$finish;
	end
endmodule

### fp64_integer_convert.f
rtl/fic_pkg.sv
rtl/fic_int_to_dbl.sv
rtl/fp64_integer_convert.sv
rtl/fic_checker.sv
test/tb.sv
